// ===== design/vnd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnd_pkg
// Shared types and constants for the voxel normalised diffusion block.
// ---------------------------------------------------------------------------
package vnd_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ATT_MIN        = 3'd0,
        REG_WEIGHT_FACE    = 3'd1,
        REG_WEIGHT_EDGE    = 3'd2,
        REG_WEIGHT_CORNER  = 3'd3,
        REG_NBR_Z_FLOOR    = 3'd4,
        REG_CENTER_Z_FLOOR = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] ATT_MIN_RST        = 16'd0;
    localparam logic [15:0] WEIGHT_FACE_RST    = 16'd28918;
    localparam logic [15:0] WEIGHT_EDGE_RST    = 16'd25520;
    localparam logic [15:0] WEIGHT_CORNER_RST  = 16'd22521;
    localparam logic [3:0]  NBR_Z_FLOOR_RST    = 4'd2;
    localparam logic [3:0]  CENTER_Z_FLOOR_RST = 4'd2;

    localparam int unsigned NUM_NBRS = 26;
    localparam logic [4:0]  MAX_NBRS = 5'd26;

    // request kinds on tuser
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_DIFFUSE = 1'b1;

    // per-axis neighbour offset codes
    localparam logic [1:0] D_MINUS = 2'd0;
    localparam logic [1:0] D_ZERO  = 2'd1;
    localparam logic [1:0] D_PLUS  = 2'd2;

    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
        logic [1:0] dz;
    } nbr_delta_t;

    // input item as packed on s_axis_tdata
    typedef struct packed {
        logic [2:0]  pad;
        logic        frontier_in;
        logic [15:0] priority_in;
        logic [3:0]  pos_z;
        logic [3:0]  pos_y;
        logic [3:0]  pos_x;
    } in_item_t;

    // ceil(2^23 / 10): exact quotient by ten for values below 2^22
    localparam logic [19:0] RECIP_TEN = 20'd838861;
    localparam int unsigned RECIP_SHIFT = 23;

    // neighbour n of 26 in raster order over the 3x3x3 cube, centre skipped
    function automatic nbr_delta_t nbr_delta(input logic [4:0] idx);
        logic [4:0] t;
        logic [4:0] r;
        nbr_delta_t d;
        t = (idx < 5'd13) ? idx : idx + 5'd1;
        // t = 9*dx + 3*dy + dz, split by compare and subtract
        if (t >= 5'd18) begin
            d.dx = D_PLUS;
            r = t - 5'd18;
        end else if (t >= 5'd9) begin
            d.dx = D_ZERO;
            r = t - 5'd9;
        end else begin
            d.dx = D_MINUS;
            r = t;
        end
        if (r >= 5'd6) begin
            d.dy = D_PLUS;
            r = r - 5'd6;
        end else if (r >= 5'd3) begin
            d.dy = D_ZERO;
            r = r - 5'd3;
        end else begin
            d.dy = D_MINUS;
        end
        d.dz = r[1:0];
        return d;
    endfunction

endpackage

// ===== design/voxel_normalized_diffusion_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voxel_normalized_diffusion_top
// Voxel grid with in-place normalised 26-neighbour diffusion update.
// ---------------------------------------------------------------------------
// Usage:
//  s_axis: one request per transfer. tuser = 0 loads a voxel's priority and
//  frontier flag, tuser = 1 diffuses one voxel. Every request gives exactly
//  one m_axis transfer (diffusion value, new for a diffuse, and neighbour count).
//  cfg: register writes, always ready; write only while the block is idle.
// Flow:
//  A load returns the stored diffusion value. A diffuse of a frontier voxel
//  makes 26 neighbour reads, one per cycle from the single read port of the
//  grid memories, drains the neighbour pipeline, runs a 16-bit bit-serial
//  divider (skipped for a zero weight sum), blends and writes back; other
//  voxels skip to write-back. One request at a time: tready high only when idle.
// Reset:
//  After aresetn the grid memories are swept to zero, one voxel per cycle,
//  with s_axis_tready low.
// Stall:
//  A result waits in the output register while m_axis_tready is low; the
//  next request may be taken meanwhile and holds at its final step.
// ---------------------------------------------------------------------------
module voxel_normalized_diffusion_top #(
    parameter int DIM_X = 16,
    parameter int DIM_Y = 16,
    parameter int DIM_Z = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pos_x, pos_y, pos_z, priority_in, frontier_in
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // diffused_value, counted_nbrs
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STEP_Y   = AW'(DIM_X);
    localparam logic [AW-1:0] STEP_Z   = AW'(DIM_X * DIM_Y);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
    localparam int ACC_W = 37;
    localparam int NRM_W = 21;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CENTER, ST_SCAN, ST_DRAIN,
        ST_DIVIDE, ST_MUL, ST_NORM, ST_WRITE, ST_RESULT
    } state_t;

    // configuration
    logic [15:0] att_min_reg, w_face_reg, w_edge_reg, w_corner_reg;
    logic [3:0]  nbr_floor_reg, ctr_floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            att_min_reg   <= vnd_pkg::ATT_MIN_RST;
            w_face_reg    <= vnd_pkg::WEIGHT_FACE_RST;
            w_edge_reg    <= vnd_pkg::WEIGHT_EDGE_RST;
            w_corner_reg  <= vnd_pkg::WEIGHT_CORNER_RST;
            nbr_floor_reg <= vnd_pkg::NBR_Z_FLOOR_RST;
            ctr_floor_reg <= vnd_pkg::CENTER_Z_FLOOR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                vnd_pkg::REG_ATT_MIN:        att_min_reg   <= cfg_data;
                vnd_pkg::REG_WEIGHT_FACE:    w_face_reg    <= cfg_data;
                vnd_pkg::REG_WEIGHT_EDGE:    w_edge_reg    <= cfg_data;
                vnd_pkg::REG_WEIGHT_CORNER:  w_corner_reg  <= cfg_data;
                vnd_pkg::REG_NBR_Z_FLOOR:    nbr_floor_reg <= cfg_data[3:0];
                vnd_pkg::REG_CENTER_Z_FLOOR: ctr_floor_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    state_t            state_reg;
    logic [AW-1:0]     clr_adr_reg;
    logic              req_reg;
    logic [3:0]        cx_reg, cy_reg, cz_reg;
    logic [AW-1:0]     cadr_reg;
    logic [15:0]       old_reg;
    logic [4:0]        k_reg;
    logic [15:0]       res_val_reg;
    logic [4:0]        res_cnt_reg;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    // neighbour pipeline
    logic              p1_v_reg, p2_v_reg, p3_v_reg;
    logic [1:0]        p1_cls_reg;
    logic [15:0]       p2_att_reg, p2_w_reg, p3_w_reg;
    logic [31:0]       p3_prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [NRM_W-1:0]  norm_reg;
    logic [4:0]        cnt_reg;

    // divider and blend
    logic [NRM_W-1:0]  rem_reg;
    logic [15:0]       num_lo_reg;
    logic [15:0]       quot_reg;
    logic [3:0]        div_cnt_reg;
    logic [39:0]       blend_prod_reg;

    // memories
    logic [16:0]       pf_mem [DEPTH];
    logic [15:0]       diff_mem [DEPTH];
    logic [16:0]       pf_q;
    logic [15:0]       diff_q;
    logic [AW-1:0]     rd_adr;
    logic              pf_we, diff_we;
    logic [AW-1:0]     pf_wadr, diff_wadr;
    logic [16:0]       pf_wdata;
    logic [15:0]       diff_wdata;

    always_ff @(posedge aclk) begin
        if (pf_we) begin
            pf_mem[pf_wadr] <= pf_wdata;
        end
        pf_q <= pf_mem[rd_adr];
    end

    always_ff @(posedge aclk) begin
        if (diff_we) begin
            diff_mem[diff_wadr] <= diff_wdata;
        end
        diff_q <= diff_mem[rd_adr];
    end

    // input decode
    vnd_pkg::in_item_t in_item;
    logic              in_grid;
    logic [AW-1:0]     in_adr;
    logic              s_fire;

    assign in_item = vnd_pkg::in_item_t'(s_axis_tdata);
    assign in_grid = ({5'd0, in_item.pos_x} < 9'(DIM_X)) &&
                     ({5'd0, in_item.pos_y} < 9'(DIM_Y)) &&
                     ({5'd0, in_item.pos_z} < 9'(DIM_Z));
    assign in_adr  = AW'(in_item.pos_x) + STEP_Y * AW'(in_item.pos_y)
                   + STEP_Z * AW'(in_item.pos_z);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire  = s_axis_tvalid && s_axis_tready;

    // neighbour address and qualification
    vnd_pkg::nbr_delta_t dlt;
    logic [AW-1:0]       term_x, term_y, term_z, nbr_adr;
    logic                ok_x, ok_y, ok_z, nbr_ok;
    logic [4:0]          nz;
    logic [1:0]          nbr_cls;

    always_comb begin
        dlt = vnd_pkg::nbr_delta(k_reg);
        term_x = (dlt.dx == vnd_pkg::D_MINUS) ? '1 :
                 (dlt.dx == vnd_pkg::D_PLUS)  ? AW'(1) : '0;
        term_y = (dlt.dy == vnd_pkg::D_MINUS) ? AW'(0) - STEP_Y :
                 (dlt.dy == vnd_pkg::D_PLUS)  ? STEP_Y : '0;
        term_z = (dlt.dz == vnd_pkg::D_MINUS) ? AW'(0) - STEP_Z :
                 (dlt.dz == vnd_pkg::D_PLUS)  ? STEP_Z : '0;
        nbr_adr = cadr_reg + term_x + term_y + term_z;
        ok_x = (dlt.dx == vnd_pkg::D_MINUS) ? (cx_reg != 4'd0) :
               (dlt.dx == vnd_pkg::D_PLUS)  ? ({5'd0, cx_reg} + 9'd1 < 9'(DIM_X)) : 1'b1;
        ok_y = (dlt.dy == vnd_pkg::D_MINUS) ? (cy_reg != 4'd0) :
               (dlt.dy == vnd_pkg::D_PLUS)  ? ({5'd0, cy_reg} + 9'd1 < 9'(DIM_Y)) : 1'b1;
        ok_z = (dlt.dz == vnd_pkg::D_MINUS) ? (cz_reg != 4'd0) :
               (dlt.dz == vnd_pkg::D_PLUS)  ? ({5'd0, cz_reg} + 9'd1 < 9'(DIM_Z)) : 1'b1;
        nz = (dlt.dz == vnd_pkg::D_MINUS) ? {1'b0, cz_reg} - 5'd1 :
             (dlt.dz == vnd_pkg::D_PLUS)  ? {1'b0, cz_reg} + 5'd1 : {1'b0, cz_reg};
        nbr_ok  = ok_x && ok_y && ok_z && (nz > {1'b0, nbr_floor_reg});
        nbr_cls = 2'(dlt.dx != vnd_pkg::D_ZERO) + 2'(dlt.dy != vnd_pkg::D_ZERO)
                + 2'(dlt.dz != vnd_pkg::D_ZERO);
    end

    // memory port control
    always_comb begin
        rd_adr     = (state_reg == ST_SCAN) ? nbr_adr : in_adr;
        pf_we      = (state_reg == ST_CLEAR) ||
                     (s_fire && in_grid && (s_axis_tuser[0] == vnd_pkg::REQ_LOAD));
        pf_wadr    = (state_reg == ST_CLEAR) ? clr_adr_reg : in_adr;
        pf_wdata   = (state_reg == ST_CLEAR) ? 17'd0 :
                     {in_item.frontier_in, in_item.priority_in};
        diff_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        diff_wadr  = (state_reg == ST_CLEAR) ? clr_adr_reg : cadr_reg;
        diff_wdata = (state_reg == ST_CLEAR) ? 16'd0 : res_val_reg;
    end

    // attention of the neighbour whose data is on the read port
    logic [16:0] att_sum;
    logic [15:0] att;
    logic [15:0] w_sel;

    always_comb begin
        att_sum = {1'b0, pf_q[15:0]} + {1'b0, diff_q};
        att     = att_sum[16] ? 16'hFFFF : att_sum[15:0];
        case (p1_cls_reg)
            2'd1:    w_sel = w_face_reg;
            2'd2:    w_sel = w_edge_reg;
            default: w_sel = w_corner_reg;
        endcase
    end

    logic [ACC_W-1:0] div_num;
    logic [NRM_W:0]   div_trial;
    logic [19:0]      blend_sum;

    assign div_num   = acc_reg + ACC_W'(norm_reg >> 1);
    assign div_trial = {rem_reg, num_lo_reg[15]};
    assign blend_sum = 20'({quot_reg, 3'd0}) + 20'(quot_reg) + 20'(old_reg) + 20'd5;

    always_ff @(posedge aclk) begin
        // pipeline data stages run freely; valid bits gate the accumulation
        p1_cls_reg  <= nbr_cls;
        p2_att_reg  <= att;
        p2_w_reg    <= w_sel;
        p3_prod_reg <= p2_w_reg * p2_att_reg;
        p3_w_reg    <= p2_w_reg;

        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_adr_reg <= '0;
            m_valid_reg <= 1'b0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            p3_v_reg    <= 1'b0;
        end else begin
            p1_v_reg <= (state_reg == ST_SCAN) && nbr_ok;
            p2_v_reg <= p1_v_reg && (att >= att_min_reg);
            p3_v_reg <= p2_v_reg;
            if (m_valid_reg && m_axis_tready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            if (p3_v_reg) begin
                acc_reg  <= acc_reg + ACC_W'(p3_prod_reg);
                norm_reg <= norm_reg + NRM_W'(p3_w_reg);
                cnt_reg  <= cnt_reg + 5'd1;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_adr_reg <= clr_adr_reg + AW'(1);
                    if (clr_adr_reg == LAST_ADR) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        req_reg  <= s_axis_tuser[0];
                        cx_reg   <= in_item.pos_x;
                        cy_reg   <= in_item.pos_y;
                        cz_reg   <= in_item.pos_z;
                        cadr_reg <= in_adr;
                        if (in_grid) begin
                            state_reg <= ST_CENTER;
                        end else begin
                            res_val_reg <= 16'd0;
                            res_cnt_reg <= 5'd0;
                            state_reg   <= ST_RESULT;
                        end
                    end
                end
                ST_CENTER: begin
                    old_reg  <= diff_q;
                    acc_reg  <= '0;
                    norm_reg <= '0;
                    cnt_reg  <= '0;
                    k_reg    <= '0;
                    res_cnt_reg <= 5'd0;
                    if (req_reg == vnd_pkg::REQ_LOAD) begin
                        res_val_reg <= diff_q;
                        state_reg   <= ST_RESULT;
                    end else if (!pf_q[16] || (cz_reg <= ctr_floor_reg)) begin
                        res_val_reg <= 16'd0;
                        state_reg   <= ST_WRITE;
                    end else begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    k_reg <= k_reg + 5'd1;
                    if (k_reg == 5'(vnd_pkg::NUM_NBRS - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!p1_v_reg && !p2_v_reg && !p3_v_reg) begin
                        res_cnt_reg <= cnt_reg;
                        if (norm_reg == '0) begin
                            quot_reg  <= att_min_reg;
                            state_reg <= ST_MUL;
                        end else begin
                            rem_reg     <= div_num[ACC_W-1:16];
                            num_lo_reg  <= div_num[15:0];
                            div_cnt_reg <= '0;
                            state_reg   <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    // restoring division, one quotient bit per cycle
                    num_lo_reg  <= {num_lo_reg[14:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_trial >= {1'b0, norm_reg}) begin
                        rem_reg  <= NRM_W'(div_trial - {1'b0, norm_reg});
                        quot_reg <= {quot_reg[14:0], 1'b1};
                    end else begin
                        rem_reg  <= div_trial[NRM_W-1:0];
                        quot_reg <= {quot_reg[14:0], 1'b0};
                    end
                    if (div_cnt_reg == 4'd15) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    blend_prod_reg <= blend_sum * vnd_pkg::RECIP_TEN;
                    state_reg      <= ST_NORM;
                end
                ST_NORM: begin
                    res_val_reg <= blend_prod_reg[vnd_pkg::RECIP_SHIFT +: 16];
                    state_reg   <= ST_WRITE;
                end
                ST_WRITE: begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'd0, res_cnt_reg, res_val_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== design/vnd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnd_checker
// Port-level checks for the voxel normalised diffusion block.
// ---------------------------------------------------------------------------
module vnd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a result waiting for the receiver stays
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // never more neighbours than the kernel has
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[20:16] <= vnd_pkg::MAX_NBRS)
        else $error("counted_nbrs out of range");

    // one request in flight: no transfer right after a transfer
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // a load or diffuse taken while no result waits does not raise m_axis_tvalid at once
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind voxel_normalized_diffusion_top vnd_checker u_vnd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Voxel diffusion block: random loads and diffuses, predicted results
// compared per transfer, config changed between phases.
// ---------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic        req;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        logic [15:0] prio;
        logic        front;
    } voxel_req_t;

    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  nbrs;
    } voxel_res_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic [0:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;

    voxel_normalized_diffusion_top dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // predictor state
    logic [15:0] prio_grid [4096];
    logic        front_grid [4096];
    logic [15:0] diff_grid [4096];
    logic [15:0] p_att_min, p_wf, p_we, p_wc;
    logic [3:0]  p_nfloor, p_cfloor;

    voxel_req_t  pending_reqs [$];
    voxel_res_t  expected_res [$];
    int          send_idle = 0, recv_stall = 0;
    bit          failed = 0;

    function automatic int unsigned attention(int a);
        int unsigned s;
        s = prio_grid[a] + diff_grid[a];
        return s > 65535 ? 65535 : s;
    endfunction

    function automatic voxel_res_t predict_voxel(voxel_req_t r);
        voxel_res_t res;
        int a, nx, ny, nz, axes, na;
        longint unsigned acc, norm, w, att, conv, v;
        int n;
        res = '0;
        a = r.x + 16 * (r.y + 16 * r.z);
        if (r.req == vnd_pkg::REQ_LOAD) begin
            prio_grid[a] = r.prio;
            front_grid[a] = r.front;
            res.value = diff_grid[a];
            return res;
        end
        n = 0;
        if (!front_grid[a] || r.z <= p_cfloor) begin
            v = 0;
        end else begin
            acc = 0; norm = 0;
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++) begin
                        nx = r.x + dx; ny = r.y + dy; nz = r.z + dz;
                        if (dx == 0 && dy == 0 && dz == 0) continue;
                        if (nx < 0 || ny < 0 || nz < 0 || nx > 15 || ny > 15 || nz > 15)
                            continue;
                        if (nz <= p_nfloor) continue;
                        na = nx + 16 * (ny + 16 * nz);
                        att = attention(na);
                        if (att < p_att_min) continue;
                        axes = (dx != 0) + (dy != 0) + (dz != 0);
                        w = axes == 1 ? p_wf : (axes == 2 ? p_we : p_wc);
                        acc += w * att;
                        norm += w;
                        n++;
                    end
            if (norm == 0) conv = p_att_min;
            else begin
                conv = (acc + norm / 2) / norm;
                if (conv > 65535) conv = 65535;
            end
            v = (9 * conv + diff_grid[a] + 5) / 10;
            if (v > 65535) v = 65535;
        end
        diff_grid[a] = v[15:0];
        res.value = v[15:0];
        res.nbrs = n[4:0];
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    voxel_req_t r;
                    r = pending_reqs.pop_front();
                    expected_res = {expected_res, predict_voxel(r)};
                    s_axis_tvalid <= 1;
                    s_axis_tuser <= r.req;
                    s_axis_tdata <= {3'b0, r.front, r.prio, r.z, r.y, r.x};
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            voxel_res_t e;
            if (expected_res.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                failed = 1;
            end else begin
                e = expected_res.pop_front();
                if (m_axis_tdata[15:0] !== e.value) begin
                    $error("diffused_value expected %0d actual %0d", e.value,
                           m_axis_tdata[15:0]);
                    failed = 1;
                end
                if (m_axis_tdata[20:16] !== e.nbrs) begin
                    $error("counted_nbrs expected %0d actual %0d", e.nbrs,
                           m_axis_tdata[20:16]);
                    failed = 1;
                end
            end
        end
    end

    task automatic write_reg(vnd_pkg::cfg_reg_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            vnd_pkg::REG_ATT_MIN:        p_att_min = val;
            vnd_pkg::REG_WEIGHT_FACE:    p_wf = val;
            vnd_pkg::REG_WEIGHT_EDGE:    p_we = val;
            vnd_pkg::REG_WEIGHT_CORNER:  p_wc = val;
            vnd_pkg::REG_NBR_Z_FLOOR:    p_nfloor = val[3:0];
            vnd_pkg::REG_CENTER_Z_FLOOR: p_cfloor = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic add_req(voxel_req_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    function automatic voxel_req_t mk(logic rq, int x, int y, int z, int p, logic f);
        voxel_req_t r;
        r.req = rq; r.x = 4'(x); r.y = 4'(y); r.z = 4'(z); r.prio = 16'(p); r.front = f;
        return r;
    endfunction

    // loads and diffuses mixed in a small cube that moves now and then, some anywhere
    task automatic queue_random(int n);
        int bx, by, bz;
        bx = $urandom_range(13); by = $urandom_range(13); bz = $urandom_range(13);
        for (int i = 0; i < n; i++) begin
            voxel_req_t r;
            r = mk($urandom_range(99) < 45, bx + $urandom_range(2), by + $urandom_range(2),
                   bz + $urandom_range(2), $urandom, $urandom_range(99) < 75);
            if ($urandom_range(9) == 0) begin
                r.x = 4'($urandom); r.y = 4'($urandom); r.z = 4'($urandom);
            end
            if ($urandom_range(7) == 0) r.prio = $urandom_range(1) ? 16'hffff : 16'h0;
            if ($urandom_range(29) == 0) begin
                bx = $urandom_range(13); by = $urandom_range(13); bz = $urandom_range(13);
            end
            add_req(r);
        end
    endtask

    initial begin
        int idle_tab [4] = '{0, 68, 0, 30};
        int stall_tab [4] = '{0, 0, 68, 30};
        p_att_min = vnd_pkg::ATT_MIN_RST; p_wf = vnd_pkg::WEIGHT_FACE_RST;
        p_we = vnd_pkg::WEIGHT_EDGE_RST; p_wc = vnd_pkg::WEIGHT_CORNER_RST;
        p_nfloor = vnd_pkg::NBR_Z_FLOOR_RST; p_cfloor = vnd_pkg::CENTER_Z_FLOOR_RST;
        for (int i = 0; i < 4096; i++) begin
            prio_grid[i] = 0; front_grid[i] = 0; diff_grid[i] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // directed: corners, floors, saturation, empty neighbourhood
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 5, 5, 5, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_LOAD, 5, 5, 5, 100, 1'b1));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 5, 5, 5, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_LOAD, 0, 0, 15, 16'hffff, 1'b1));
        add_req(mk(vnd_pkg::REQ_LOAD, 1, 1, 14, 16'hffff, 1'b1));
        add_req(mk(vnd_pkg::REQ_LOAD, 1, 0, 15, 16'h1234, 1'b0));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 0, 0, 15, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 1, 1, 14, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 0, 0, 15, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_LOAD, 15, 15, 2, 16'h8000, 1'b1));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 15, 15, 2, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_LOAD, 15, 15, 3, 16'h0001, 1'b1));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 15, 15, 3, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_LOAD, 15, 15, 0, 16'hffff, 1'b1));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 15, 15, 0, 0, 1'b1));
        wait_drained();

        write_reg(vnd_pkg::REG_ATT_MIN, 16'hffff);
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 1, 1, 14, 0, 1'b0));
        add_req(mk(vnd_pkg::REQ_DIFFUSE, 0, 0, 15, 0, 1'b0));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle = idle_tab[ph % 4];
            recv_stall = stall_tab[ph % 4];
            case (ph)
                0: begin
                    write_reg(vnd_pkg::REG_ATT_MIN, 16'd0);
                    write_reg(vnd_pkg::REG_NBR_Z_FLOOR, 16'd0);
                    write_reg(vnd_pkg::REG_CENTER_Z_FLOOR, 16'd0);
                end
                1: begin
                    write_reg(vnd_pkg::REG_WEIGHT_FACE, 16'd32768);
                    write_reg(vnd_pkg::REG_WEIGHT_EDGE, 16'd0);
                    write_reg(vnd_pkg::REG_WEIGHT_CORNER, 16'd32768);
                    write_reg(vnd_pkg::REG_ATT_MIN, 16'h0100);
                end
                2: begin
                    write_reg(vnd_pkg::REG_WEIGHT_FACE, 16'd0);
                    write_reg(vnd_pkg::REG_WEIGHT_EDGE, 16'd0);
                    write_reg(vnd_pkg::REG_WEIGHT_CORNER, 16'd0);
                end
                3: begin
                    write_reg(vnd_pkg::REG_WEIGHT_FACE, 16'hffff);
                    write_reg(vnd_pkg::REG_WEIGHT_EDGE, 16'hffff);
                    write_reg(vnd_pkg::REG_WEIGHT_CORNER, 16'hffff);
                    write_reg(vnd_pkg::REG_NBR_Z_FLOOR, 16'd15);
                end
                4: begin
                    write_reg(vnd_pkg::REG_NBR_Z_FLOOR, 16'd5);
                    write_reg(vnd_pkg::REG_CENTER_Z_FLOOR, 16'd15);
                end
                default: begin
                    write_reg(vnd_pkg::REG_ATT_MIN, 16'($urandom));
                    write_reg(vnd_pkg::REG_WEIGHT_FACE, 16'($urandom_range(32768)));
                    write_reg(vnd_pkg::REG_WEIGHT_EDGE, 16'($urandom_range(32768)));
                    write_reg(vnd_pkg::REG_WEIGHT_CORNER, 16'($urandom_range(32768)));
                    write_reg(vnd_pkg::REG_NBR_Z_FLOOR, 16'($urandom_range(4)));
                    write_reg(vnd_pkg::REG_CENTER_Z_FLOOR, 16'($urandom_range(4)));
                end
            endcase
            queue_random(105);
            wait_drained();
        end

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
